/* rtl/btda_pkg.sv */
// Shared types and constants for the binary to decimal ASCII converter.
// No dependencies; imported by binary_to_decimal_ascii.
`timescale 1ns / 1ps

package btda_pkg;

  // ascii codes used by the formatter
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;

  // configuration register indexes
  localparam logic CFG_SPACER = 1'b0;
  localparam logic CFG_PLUS   = 1'b1;

  // first power-of-ten index for each width, and the last index
  localparam logic [1:0] POW_FIRST_WIDE   = 2'd0;
  localparam logic [1:0] POW_FIRST_NARROW = 2'd2;
  localparam logic [1:0] POW_LAST         = 2'd3;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SIGN  = 4'b0010,
    S_SUB   = 4'b0100,
    S_FINAL = 4'b1000
  } state_t;

  // power of ten for each digit position, most significant first
  function automatic logic [15:0] pow10(input logic [1:0] idx);
    logic [15:0] p;
    begin
      case (idx)
        2'd0:    p = 16'd10000;
        2'd1:    p = 16'd1000;
        2'd2:    p = 16'd100;
        default: p = 16'd10;
      endcase
      return p;
    end
  endfunction

endpackage

/* rtl/binary_to_decimal_ascii.sv */
// Binary to decimal ASCII converter: one number in, its characters out.
// After an item is accepted, the sequencer handles the sign slot, then for each digit position
// subtracts the power of ten until a borrow and emits the digit, and last emits the final
// digit; output stalls can hold any step that emits a character.
// One 17-bit subtractor does all the digit work; in_ready is high only in the idle state, so
// a number is taken only after the last one has left the sequencer. Synchronous reset clears
// the sequencer, output valid and both config registers.
`timescale 1ns / 1ps

module binary_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] value,
  input  logic [1:0]  mode,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic        last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  import btda_pkg::*;

  state_t      state;
  logic [7:0]  spacer_char;
  logic [7:0]  plus_char;
  logic [15:0] mag;
  logic        neg;
  logic        sgn;
  logic        leading;
  logic [1:0]  idx;
  logic [3:0]  digit;

  logic [15:0] pow;
  logic [16:0] diff;
  logic        borrow;
  logic        can_emit;
  logic        emit_en;
  logic [7:0]  emit_char;
  logic        emit_last;
  logic        fire;
  logic        in_wide;
  logic        in_neg;
  logic [15:0] in_mag;
  logic [7:0]  neg_lo;
  logic [15:0] neg_full;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      spacer_char <= '0;
      plus_char   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SPACER: spacer_char <= cfg_data;
        CFG_PLUS:   plus_char   <= cfg_data;
        default:    ;
      endcase
    end
  end

  // magnitude of the incoming number
  always_comb begin
    in_wide  = mode[1];
    neg_lo   = ~value[7:0] + 8'd1;
    neg_full = ~value + 16'd1;
    if (in_wide) begin
      in_neg = mode[0] & value[15];
      in_mag = in_neg ? neg_full : value;
    end else begin
      in_neg = mode[0] & value[7];
      in_mag = {8'd0, (in_neg ? neg_lo : value[7:0])};
    end
  end

  // shared subtractor against the current power of ten
  assign pow    = pow10(idx);
  assign diff   = {1'b0, mag} - {1'b0, pow};
  assign borrow = diff[16];

  assign in_ready = (state == S_IDLE);
  assign can_emit = !out_valid || out_ready;

  // character selection for the current step
  always_comb begin
    emit_en   = 1'b0;
    emit_char = CHAR_ZERO;
    emit_last = 1'b0;
    unique case (state)
      S_IDLE: ;
      S_SIGN: begin
        if (neg) begin
          emit_en   = 1'b1;
          emit_char = CHAR_MINUS;
        end else if (sgn && plus_char != 8'd0) begin
          emit_en   = 1'b1;
          emit_char = plus_char;
        end
      end
      S_SUB: begin
        if (borrow) begin
          if (digit != 4'd0) begin
            emit_en   = 1'b1;
            emit_char = CHAR_ZERO + {4'd0, digit};
          end else if (spacer_char == CHAR_ZERO || !leading) begin
            emit_en   = 1'b1;
          end else if (spacer_char != 8'd0) begin
            emit_en   = 1'b1;
            emit_char = spacer_char;
          end
        end
      end
      S_FINAL: begin
        emit_en   = 1'b1;
        emit_char = CHAR_ZERO + {4'd0, mag[3:0]};
        emit_last = 1'b1;
      end
      default: ;
    endcase
  end

  assign fire = emit_en && can_emit;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            mag     <= in_mag;
            neg     <= in_neg;
            sgn     <= mode[0];
            leading <= 1'b1;
            digit   <= 4'd0;
            idx     <= in_wide ? POW_FIRST_WIDE : POW_FIRST_NARROW;
            state   <= S_SIGN;
          end
        end
        S_SIGN: begin
          if (!emit_en || can_emit) begin
            state <= S_SUB;
          end
        end
        S_SUB: begin
          if (!borrow) begin
            mag   <= diff[15:0];
            digit <= digit + 4'd1;
          end else if (!emit_en || can_emit) begin
            if (digit != 4'd0) begin
              leading <= 1'b0;
            end
            digit <= 4'd0;
            if (idx == POW_LAST) begin
              state <= S_FINAL;
            end else begin
              idx <= idx + 2'd1;
            end
          end
        end
        S_FINAL: begin
          if (can_emit) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_char <= emit_char;
      last     <= emit_last;
    end
  end

  // a digit count stays a decimal digit
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SUB) |-> (digit <= 4'd9))
    else $error("digit count out of range");

  // remainder stays below ten times the current power
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SUB) |-> ({1'b0, mag} < 17'(pow) * 17'd10))
    else $error("remainder too large for digit position");

  // leaving the final step presents the last character
  assert property (@(posedge clk) disable iff (rst)
    (state == S_FINAL && can_emit) |=> (out_valid && last && state == S_IDLE))
    else $error("final character not presented");

endmodule

/* dv/btda_sb_pkg.sv */
// Scoreboard for the binary to decimal ASCII converter testbench.
// Holds the number modes, a character predictor and the expected-character store.
// Depends on btda_pkg for the ascii codes and register indexes.
`timescale 1ns / 1ps

package btda_sb_pkg;

  import btda_pkg::*;

  // number formats carried in the mode field
  typedef enum logic [1:0] {
    MODE_U8  = 2'd0,
    MODE_S8  = 2'd1,
    MODE_U16 = 2'd2,
    MODE_S16 = 2'd3
  } num_mode_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } ascii_char_t;

  class btda_scoreboard;
    ascii_char_t expected_chars[$];
    logic [7:0]  spacer;
    logic [7:0]  plus;
    int          errors;

    function new();
      spacer = 8'd0;
      plus   = 8'd0;
      errors = 0;
    endfunction

    // mirror of the configuration registers
    function void set_reg(input logic idx, input logic [7:0] d);
      if (idx == CFG_SPACER) begin
        spacer = d;
      end else begin
        plus = d;
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    function void push_char(input logic [7:0] c, input logic l);
      ascii_char_t e;
      e.ch   = c;
      e.last = l;
      expected_chars.push_back(e);
    endfunction

    // format one accepted number into its expected characters
    function void note_input(input logic [15:0] v, input num_mode_t m);
      int unsigned decade[4] = '{10000, 1000, 100, 10};
      logic        wide;
      logic        sgn;
      logic        neg;
      logic        leading;
      int unsigned mag;
      int unsigned d;
      int          first;
      wide = (m == MODE_U16) || (m == MODE_S16);
      sgn  = (m == MODE_S8) || (m == MODE_S16);
      if (wide) begin
        neg = sgn && v[15];
        mag = neg ? (32'h10000 - v) : v;
      end else begin
        neg = sgn && v[7];
        mag = neg ? (32'h100 - v[7:0]) : v[7:0];
      end
      // sign slot
      if (neg) begin
        push_char(CHAR_MINUS, 1'b0);
      end else if (sgn && plus != 8'd0) begin
        push_char(plus, 1'b0);
      end
      // digit positions by repeated subtraction
      leading = 1'b1;
      first   = wide ? 0 : 2;
      for (int i = first; i < 4; i++) begin
        d = 0;
        while (mag >= decade[i]) begin
          mag -= decade[i];
          d++;
        end
        if (d != 0) begin
          push_char(CHAR_ZERO + 8'(d), 1'b0);
          leading = 1'b0;
        end else if (spacer == CHAR_ZERO || !leading) begin
          push_char(CHAR_ZERO, 1'b0);
        end else if (spacer != 8'd0) begin
          push_char(spacer, 1'b0);
        end
      end
      // units digit always goes out and closes the number
      push_char(CHAR_ZERO + 8'(mag[3:0]), 1'b1);
    endfunction

    task report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // compare one accepted character with the oldest expectation
    task check_result(input logic [7:0] c, input logic l);
      ascii_char_t e;
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected item char=%02h last=%0b", c, l));
      end else begin
        e = expected_chars.pop_front();
        if (c !== e.ch) begin
          report_mismatch($sformatf("out_char %02h, expected %02h", c, e.ch));
        end
        if (l !== e.last) begin
          report_mismatch($sformatf("last %0b, expected %0b (char %02h)", l, e.last, e.ch));
        end
      end
    endtask
  endclass

endpackage

/* dv/tb_binary_to_decimal_ascii.sv */
// Top-level testbench for binary_to_decimal_ascii.
// Drives numbers in all four modes under several register settings with random
// sender bursts and receiver stalls; depends on btda_pkg and btda_sb_pkg.
`timescale 1ns / 1ps

module tb_binary_to_decimal_ascii;

  import btda_pkg::*;
  import btda_sb_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 50;
  localparam int PHASE_ITEMS   = 49;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [15:0] value     = 16'd0;
  logic [1:0]  mode      = MODE_U8;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_char;
  logic        last;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = CFG_SPACER;
  logic [7:0]  cfg_data  = 8'd0;

  int          cycle_count = 0;
  int          rx_cycle    = 0;
  int          rx_style    = 0;

  btda_scoreboard sb = new();

  binary_to_decimal_ascii u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .mode      (mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .last      (last),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: switches between stall styles every so often
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 150 == 0) begin
      rx_style <= $urandom_range(0, 3);
    end
    case (rx_style)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (rx_cycle % 4 != 0);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // monitor both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        sb.note_input(value, num_mode_t'(mode));
      end
      if (out_valid && out_ready) begin
        sb.check_result(out_char, last);
      end
    end
  end

  // present one item and hold it until accepted; returns just after the edge
  task automatic send_item(input logic [15:0] v, input num_mode_t m);
    in_valid <= 1'b1;
    value    <= v;
    mode     <= m;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic pause_sender(input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off until every expected character has come out
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one register write, after which the write enable goes low again
  task automatic write_cfg(input logic idx, input logic [7:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, d);
    @(posedge clk);
  endtask

  // values biased toward sign edges, powers of ten and small numbers
  function automatic logic [15:0] pick_value();
    logic [15:0] v;
    int unsigned decade[4] = '{10000, 1000, 100, 10};
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 20);
      1: v = {8'($urandom), 8'($urandom_range(8'h7c, 8'h83))} ^ ($urandom_range(0, 1) ? 16'h0 : 16'h0080);
      2: v = 16'(decade[$urandom_range(0, 3)] + $urandom_range(0, 2) - 1);
      3: v = 16'h8000 + 16'($urandom_range(0, 2)) - 16'd1 + ($urandom_range(0, 1) ? 16'h8000 : 16'h0);
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  task automatic run_random(input int count);
    int burst;
    burst = $urandom_range(1, 12);
    for (int n = 0; n < count; n++) begin
      send_item(pick_value(), num_mode_t'($urandom_range(0, 3)));
      burst--;
      if (burst == 0) begin
        pause_sender($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 10));
        burst = $urandom_range(1, 12);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed numbers under reset settings
    send_item(16'h0000, MODE_U8);
    send_item(16'h00ff, MODE_U8);
    send_item(16'h0064, MODE_U8);
    send_item(16'h000a, MODE_U8);
    send_item(16'hff05, MODE_U8);
    send_item(16'h0080, MODE_S8);
    send_item(16'h007f, MODE_S8);
    send_item(16'h00ff, MODE_S8);
    send_item(16'ha500, MODE_S8);
    pause_sender(3);
    send_item(16'h0000, MODE_U16);
    send_item(16'hffff, MODE_U16);
    send_item(16'd10000, MODE_U16);
    send_item(16'd1000, MODE_U16);
    send_item(16'd10009, MODE_U16);
    send_item(16'h8000, MODE_S16);
    send_item(16'h7fff, MODE_S16);
    send_item(16'hffff, MODE_S16);
    send_item(16'h0000, MODE_S16);
    send_item(16'h0001, MODE_S16);
    wait_drain();

    // random numbers under a range of register settings
    run_random(PHASE_ITEMS);
    wait_drain();
    write_cfg(CFG_SPACER, CHAR_ZERO);
    write_cfg(CFG_PLUS, 8'h00);
    run_random(PHASE_ITEMS);
    wait_drain();
    write_cfg(CFG_SPACER, 8'h20);
    write_cfg(CFG_PLUS, 8'h2b);
    run_random(PHASE_ITEMS);
    wait_drain();
    write_cfg(CFG_SPACER, 8'hff);
    write_cfg(CFG_PLUS, 8'hff);
    run_random(PHASE_ITEMS);
    wait_drain();
    write_cfg(CFG_SPACER, 8'h00);
    write_cfg(CFG_PLUS, 8'h2b);
    run_random(PHASE_ITEMS);
    wait_drain();
    write_cfg(CFG_SPACER, 8'($urandom));
    write_cfg(CFG_PLUS, 8'($urandom));
    run_random(PHASE_ITEMS);
    wait_drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
